// ===== rtl/mlmc_pkg.sv =====
`default_nettype none

package mlmc_pkg;

    localparam int ELEM_W = 16;
    localparam int COUNT_W = 12;
    localparam int SIZE_W = 7;
    localparam int MAX_SIZE_DEFAULT = 64;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SIZE_W-1:0] size_t;

    // flags that travel with an item from the position counters to the detector
    typedef struct packed {
        logic row_ge2;
        logic col_ge2;
        logic last_item;
    } pos_ctrl_t;

    // one column of the two line stores: row above and the row above that
    typedef struct packed {
        elem_t newer;
        elem_t older;
    } line_pair_t;

endpackage

`default_nettype wire

// ===== rtl/mlmc_if.sv =====
`default_nettype none

interface mlmc_elem_if;
    logic valid;
    logic ready;
    mlmc_pkg::elem_t element_value;

    modport source (output valid, output element_value, input ready);
    modport sink (input valid, input element_value, output ready);
endinterface

interface mlmc_count_if;
    logic valid;
    logic ready;
    mlmc_pkg::count_t minimum_count;

    modport source (output valid, output minimum_count, input ready);
    modport sink (input valid, input minimum_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/mlmc_line_store.sv =====
`default_nettype none

module mlmc_line_store #(
    parameter int DEPTH = mlmc_pkg::MAX_SIZE_DEFAULT,
    parameter int AW = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output mlmc_pkg::line_pair_t      rd_data,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire mlmc_pkg::line_pair_t wr_data
);

    mlmc_pkg::line_pair_t mem [DEPTH];
    mlmc_pkg::line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/mlmc_position.sv =====
`default_nettype none

module mlmc_position #(
    parameter int MAX_SIZE = mlmc_pkg::MAX_SIZE_DEFAULT,
    parameter int COL_W = $clog2(MAX_SIZE)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 size_wr_en,
    input  wire mlmc_pkg::size_t      size_wr_data,
    input  wire logic                 advance,
    output logic [COL_W-1:0]          col,
    output mlmc_pkg::pos_ctrl_t       ctrl
);

    localparam int SW = $clog2(MAX_SIZE + 1);
    localparam int CMP_W = (SW > mlmc_pkg::SIZE_W) ? SW : mlmc_pkg::SIZE_W;

    mlmc_pkg::size_t size_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] row_reg;
    logic [COL_W-1:0] row_next;
    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] side;
    logic [CMP_W-1:0] last_idx;
    logic col_last;
    logic row_last;

    always_comb
    begin
        size_ext = CMP_W'(size_reg);
        if (size_ext == '0)
        begin
            side = CMP_W'(1);
        end
        else if (size_ext > CMP_W'(MAX_SIZE))
        begin
            side = CMP_W'(MAX_SIZE);
        end
        else
        begin
            side = size_ext;
        end
        last_idx = side - CMP_W'(1);
        col_last = (CMP_W'(col_reg) == last_idx);
        row_last = (CMP_W'(row_reg) == last_idx);

        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + COL_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end

        ctrl.row_ge2 = (row_reg >= COL_W'(2));
        ctrl.col_ge2 = (col_reg >= COL_W'(2));
        ctrl.last_item = col_last && row_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= mlmc_pkg::SIZE_RESET;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (size_wr_en)
        begin
            size_reg <= size_wr_data;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;

endmodule

`default_nettype wire

// ===== rtl/mlmc_detect.sv =====
`default_nettype none

module mlmc_detect #(
    parameter int MAX_SIZE = mlmc_pkg::MAX_SIZE_DEFAULT,
    parameter int COL_W = $clog2(MAX_SIZE)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 restart,
    input  wire logic                 in_accept,
    input  wire mlmc_pkg::elem_t      in_value,
    input  wire logic [COL_W-1:0]     in_col,
    input  wire mlmc_pkg::pos_ctrl_t  in_ctrl,
    output logic                      in_ready,
    input  wire mlmc_pkg::line_pair_t rd_data,
    output logic                      wr_en,
    output logic [COL_W-1:0]          wr_addr,
    output mlmc_pkg::line_pair_t      wr_data,
    mlmc_count_if.source              result
);

    logic s1_valid_reg;
    mlmc_pkg::pos_ctrl_t s1_ctrl_reg;
    logic [COL_W-1:0] s1_col_reg;
    mlmc_pkg::elem_t s1_value_reg;

    // window: centre and left from the row above, above-centre, and below-centre
    mlmc_pkg::elem_t p1_hi_reg;
    mlmc_pkg::elem_t p2_hi_reg;
    mlmc_pkg::elem_t prev_lo_reg;
    mlmc_pkg::elem_t prev_x_reg;

    mlmc_pkg::count_t count_reg;
    mlmc_pkg::count_t count_next;
    logic out_valid_reg;
    mlmc_pkg::count_t out_count_reg;

    logic advance;
    logic hit;

    always_comb
    begin
        advance = s1_valid_reg
            && (!s1_ctrl_reg.last_item || !out_valid_reg || result.ready);
        in_ready = !s1_valid_reg || advance;

        hit = s1_ctrl_reg.row_ge2 && s1_ctrl_reg.col_ge2
            && (p1_hi_reg < prev_lo_reg)
            && (p1_hi_reg < prev_x_reg)
            && (p1_hi_reg < p2_hi_reg)
            && (p1_hi_reg < rd_data.newer);
        count_next = count_reg + mlmc_pkg::COUNT_W'(hit);

        wr_en = advance;
        wr_addr = s1_col_reg;
        wr_data.newer = s1_value_reg;
        wr_data.older = rd_data.newer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (restart)
            begin
                count_reg <= '0;
            end
            else if (advance)
            begin
                count_reg <= s1_ctrl_reg.last_item ? '0 : count_next;
            end

            if (advance && s1_ctrl_reg.last_item)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ctrl_reg <= in_ctrl;
            s1_col_reg <= in_col;
            s1_value_reg <= in_value;
        end
        if (advance)
        begin
            p2_hi_reg <= p1_hi_reg;
            p1_hi_reg <= rd_data.newer;
            prev_lo_reg <= rd_data.older;
            prev_x_reg <= s1_value_reg;
            if (s1_ctrl_reg.last_item)
            begin
                out_count_reg <= count_next;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.minimum_count = out_count_reg;

endmodule

`default_nettype wire

// ===== rtl/matrix_local_minimum_counter.sv =====
// pipeline: 2 register stages, input then result; a matrix's count is
// registered as its last element advances out of the input stage
// throughput: 1 element per cycle, one registered line-store read per element
// stalls only while a matrix's last element waits behind a count not yet taken
// reset: asynchronous active low, clears position, count and valid flags
// reset size register to 64; line stores are not cleared, no clearing pass
`default_nettype none

module matrix_local_minimum_counter #(
    parameter int MAX_SIZE = mlmc_pkg::MAX_SIZE_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 matrix_size_wr_en,
    input  wire mlmc_pkg::size_t      matrix_size_wr_data,
    mlmc_elem_if.sink                 elem,
    mlmc_count_if.source              result
);

    localparam int COL_W = $clog2(MAX_SIZE);

    logic accept;
    logic in_ready;
    logic [COL_W-1:0] col_idx;
    mlmc_pkg::pos_ctrl_t pos_ctrl;
    mlmc_pkg::line_pair_t rd_data;
    logic wr_en;
    logic [COL_W-1:0] wr_addr;
    mlmc_pkg::line_pair_t wr_data;

    assign elem.ready = in_ready;
    assign accept = elem.valid && in_ready;

    mlmc_position #(
        .MAX_SIZE (MAX_SIZE),
        .COL_W    (COL_W)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .size_wr_en   (matrix_size_wr_en),
        .size_wr_data (matrix_size_wr_data),
        .advance      (accept),
        .col          (col_idx),
        .ctrl         (pos_ctrl)
    );

    mlmc_line_store #(
        .DEPTH (MAX_SIZE),
        .AW    (COL_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mlmc_detect #(
        .MAX_SIZE (MAX_SIZE),
        .COL_W    (COL_W)
    ) u_detect (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (matrix_size_wr_en),
        .in_accept (accept),
        .in_value  (elem.element_value),
        .in_col    (col_idx),
        .in_ctrl   (pos_ctrl),
        .in_ready  (in_ready),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .result    (result)
    );

    a_ready_only_blocked_by_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (result.valid && !result.ready)
    ) else $error("input held off without a stalled result");

    a_size_write_restarts: assert property (
        @(posedge clk) disable iff (!rst_n)
        matrix_size_wr_en |=> (col_idx == '0)
    ) else $error("size write did not restart the column position");

    a_no_write_without_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        (wr_en && accept) |-> $past(accept)
            || $past(!in_ready) || $past(wr_en)
    ) else $error("line store written with no item in flight");

endmodule

`default_nettype wire
